// File: design/sst_pkg.sv
// ---------------------------------------------------------------------------
// sst_pkg: shared types and constants for the seven-segment time scanner
// Fonts, digit select codes, reciprocal constants and the pipeline word
// that passes from the quotient stage to the segment stage.
// ---------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int SECS_W  = 16;
  localparam int PHASE_W = 10;
  localparam int HI_W    = 13;

  // configuration register indexes
  localparam logic CFG_DISPLAY_MODE = 1'b0;
  localparam logic CFG_CATHODE_POL  = 1'b1;

  // reciprocals: floor(s / d) == (s * M) >> K for every 16-bit s
  localparam logic [32:0] DIV10_M   = 33'd52429;   // K = 19
  localparam logic [32:0] DIV60_M   = 33'd34953;   // K = 21
  localparam logic [32:0] DIV100_M  = 33'd83887;   // K = 23
  localparam logic [32:0] DIV600_M  = 33'd111849;  // K = 26
  localparam logic [32:0] DIV3600_M = 33'd74566;   // K = 28

  localparam logic [PHASE_W-1:0] DOT_LIMIT  = 10'd500;
  localparam logic [PHASE_W-1:0] PHASE_WRAP = 10'd1000;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [7:0] DOT_MASK  = 8'h7f;

  localparam logic [9:0][7:0] DIGIT_FONT = {
    8'h98, 8'h80, 8'hd8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
  };

  localparam logic [7:0][7:0] SPIN_FONT = {
    8'hfe, 8'hdf, 8'hef, 8'hf7, 8'hf7, 8'hfb, 8'hfd, 8'hfe
  };

  localparam logic [3:0][7:0] SELECT_CODE = {8'h10, 8'h20, 8'h40, 8'h80};

  // one scan word after the quotient stage
  typedef struct packed {
    logic [SECS_W-1:0] lo;     // value whose low digit is wanted
    logic [HI_W-1:0]   hi;     // lo divided by the digit base
    logic              base6;  // digit base is 6, else 10
    logic [1:0]        pos;
    logic [2:0]        spin;
    logic              dot;
  } mid_t;

  function automatic logic [7:0] digit_font(input logic [3:0] d);
    logic [7:0] f;
    f = SEG_BLANK;
    if (d < 4'd10) begin
      f = DIGIT_FONT[d];
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: design/seven_segment_time_scanner_top.sv
// Throughput: one word per cycle unless out_tready back-pressures; three
//   register stages (input, quotient, output) hand words on whenever the
//   stage ahead is empty or draining.
// Reset (rst_n low, synchronous): empties all stages, clears the scan
//   position and both configuration registers.
// ---------------------------------------------------------------------------
// seven_segment_time_scanner_top: four-digit multiplexed display scanner
// Takes one scan tick per word and emits the digit select and segment
// pattern for the next scan position.
// ---------------------------------------------------------------------------
`default_nettype none

module seven_segment_time_scanner_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] seconds_left, [25:16] ms_phase, rest zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] digit_enable, [15:8] segments
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);
  import sst_pkg::*;

  logic                display_mode_r;
  logic                cathode_pol_r;
  logic [1:0]          scan_pos_r;

  logic                s1_valid_r;
  logic [SECS_W-1:0]   s1_secs_r;
  logic [PHASE_W-1:0]  s1_phase_r;
  logic [1:0]          s1_pos_r;

  logic                s2_valid_r;
  mid_t                mid_nxt;
  mid_t                mid_r;

  logic [7:0]          en_nxt, seg_nxt;
  logic [7:0]          en_r, seg_r;

  logic                adv3, adv2, in_acc;

  assign adv3      = !out_tvalid || out_tready;
  assign adv2      = !s2_valid_r || adv3;
  assign in_tready = !s1_valid_r || adv2;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= 1'b0;
      cathode_pol_r  <= 1'b0;
      scan_pos_r     <= 2'd0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DISPLAY_MODE: display_mode_r <= cfg_data;
          CFG_CATHODE_POL:  cathode_pol_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        scan_pos_r <= scan_pos_r + 2'd1;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        out_tvalid <= s2_valid_r;
      end
    end
  end

  // payload: hold while the stage ahead stalls
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_secs_r  <= in_tdata[15:0];
      s1_phase_r <= in_tdata[25:16];
      s1_pos_r   <= scan_pos_r;
    end
    if (adv2 && s1_valid_r) begin
      mid_r <= mid_nxt;
    end
    if (adv3 && s2_valid_r) begin
      en_r  <= en_nxt;
      seg_r <= seg_nxt;
    end
  end

  sst_quot u_quot (
    .secs         (s1_secs_r),
    .phase        (s1_phase_r),
    .pos          (s1_pos_r),
    .display_mode (display_mode_r),
    .mid          (mid_nxt)
  );

  sst_seg u_seg (
    .mid              (mid_r),
    .display_mode     (display_mode_r),
    .cathode_polarity (cathode_pol_r),
    .digit_enable     (en_nxt),
    .segments         (seg_nxt)
  );

  assign out_tdata = {seg_r, en_r};

endmodule

`default_nettype wire

// File: design/sst_quot.sv
// ---------------------------------------------------------------------------
// sst_quot: quotient stage
// Divides the seconds count by constants through reciprocal multiplies and
// picks the value pair that the current scan position needs.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_quot (
  input  wire logic [sst_pkg::SECS_W-1:0]  secs,
  input  wire logic [sst_pkg::PHASE_W-1:0] phase,
  input  wire logic [1:0]                  pos,
  input  wire logic                        display_mode,
  output sst_pkg::mid_t                    mid
);
  import sst_pkg::*;

  logic [32:0] p10, p60, p100, p600, p3600;
  logic [12:0] q10;
  logic [10:0] q60;
  logic [9:0]  q100;
  logic [6:0]  q600;
  logic [4:0]  q3600;

  always_comb begin
    p10   = 33'(secs) * DIV10_M;
    p60   = 33'(secs) * DIV60_M;
    p100  = 33'(secs) * DIV100_M;
    p600  = 33'(secs) * DIV600_M;
    p3600 = 33'(secs) * DIV3600_M;
    q10   = p10[31:19];
    q60   = p60[31:21];
    q100  = p100[32:23];
    q600  = p600[32:26];
    q3600 = p3600[32:28];
  end

  always_comb begin
    mid.pos  = pos;
    mid.spin = secs[2:0];
    // phase values past the wrap count as small, so they light the dot
    mid.dot  = (phase < DOT_LIMIT) || (phase >= PHASE_WRAP);
    unique case (pos)
      2'd0: begin
        mid.lo    = secs;
        mid.hi    = q10;
        mid.base6 = 1'b0;
      end
      2'd1: begin
        mid.lo    = SECS_W'(q10);
        mid.hi    = display_mode ? HI_W'(q100) : HI_W'(q60);
        mid.base6 = !display_mode;
      end
      2'd2: begin
        mid.lo    = SECS_W'(q60);
        mid.hi    = HI_W'(q600);
        mid.base6 = 1'b0;
      end
      default: begin
        mid.lo    = SECS_W'(q600);
        mid.hi    = HI_W'(q3600);
        mid.base6 = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/sst_seg.sv
// ---------------------------------------------------------------------------
// sst_seg: segment stage
// Forms the digit as a remainder, looks up its pattern or the spin pattern,
// adds the dot and applies the output polarity.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_seg (
  input  wire sst_pkg::mid_t mid,
  input  wire logic          display_mode,
  input  wire logic          cathode_polarity,
  output logic [7:0]         digit_enable,
  output logic [7:0]         segments
);
  import sst_pkg::*;

  logic [16:0] prod;
  logic [16:0] diff;
  logic [3:0]  digit;
  logic [7:0]  spin_seg;
  logic [7:0]  seg;

  always_comb begin
    prod = mid.base6 ? ((17'(mid.hi) << 2) + (17'(mid.hi) << 1))
                     : ((17'(mid.hi) << 3) + (17'(mid.hi) << 1));
    diff  = 17'(mid.lo) - prod;
    digit = diff[3:0];
    spin_seg = SPIN_FONT[mid.spin];
  end

  always_comb begin
    unique case (mid.pos)
      2'd0, 2'd1: seg = digit_font(digit);
      2'd2: begin
        if (display_mode) begin
          seg = mid.spin[2] ? SEG_BLANK : spin_seg;
        end else begin
          seg = digit_font(digit);
        end
        if (mid.dot) begin
          seg = seg & DOT_MASK;
        end
      end
      default: begin
        if (display_mode) begin
          seg = mid.spin[2] ? spin_seg : SEG_BLANK;
        end else begin
          seg = digit_font(digit);
        end
      end
    endcase
    digit_enable = cathode_polarity ? ~SELECT_CODE[mid.pos] : SELECT_CODE[mid.pos];
    segments     = cathode_polarity ? ~seg : seg;
  end

endmodule

`default_nettype wire

// File: design/sst_checker.sv
// ---------------------------------------------------------------------------
// sst_checker: port-level checks for the seven-segment time scanner
// Watches the stream ports and flags handshake and output-format slips.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset drops the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty output stage never back-pressures the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // exactly one digit selected, in either polarity
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($onehot(out_tdata[7:4]) && (out_tdata[3:0] == 4'h0)) ||
      ($onehot(~out_tdata[7:4]) && (out_tdata[3:0] == 4'hf)))
    else $error("digit select is not a single digit");

endmodule

bind seven_segment_time_scanner_top sst_checker u_sst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
